/* sv/rbsg_pkg.sv */
// shared constants, types and quarter-wave sine table for the rds bpsk sample generator
`default_nettype none

package rbsg_pkg;

    // block dimensions
    localparam int STREAM_COUNT     = 4;
    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;

    // field widths
    localparam int STREAM_W  = 3;
    localparam int STEP_W    = 24;
    localparam int GAIN_W    = 16;
    localparam int ENABLE_W  = 4;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // derived index widths
    localparam int SIDX_W  = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
    localparam int TIDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_W  = TIDX_W - 1;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // register reset values
    localparam logic [STEP_W-1:0]   PHASE_STEP_RST      = 24'd2097152;
    localparam logic [GAIN_W-1:0]   LEVEL_GAIN_RST      = 16'd32768;
    localparam logic [ENABLE_W-1:0] STREAMS_ENABLED_RST = 4'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP      = 2'd0,
        CFG_LEVEL_GAIN      = 2'd1,
        CFG_STREAMS_ENABLED = 2'd2
    } cfg_index_t;

    // payload between the phase stage and the scaling stage
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             taken;
        logic             audible;
        logic             in_range;
    } sine_stage_t;

    typedef logic [MAG_W-1:0] sine_tab_t [0:QUARTER];

    // fixed-point sine of a quarter-turn index, q15 magnitude
    function automatic logic [MAG_W-1:0] sine_q15(input int j);
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] q;
        t   = 64'(j) << (32 - TIDX_W);
        x   = (t * 64'd6746518852) >> 32;
        x2  = (x * x) >> 30;
        acc = 64'd1 << 30;
        acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd110;
        acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd72;
        acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd42;
        acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd20;
        acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 64'd6;
        s   = (x * acc) >> 30;
        q   = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[MAG_W-1:0];
    endfunction

    // table over one quarter turn, end points included
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int j = 0; j <= QUARTER; j++)
        begin
            tab[j] = sine_q15(j);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

/* sv/rbsg_phase.sv */
// per-stream phase accumulators, differential encoding and sine lookup stage
`default_nettype none

module rbsg_phase (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load,
    input  wire logic [rbsg_pkg::STREAM_W-1:0]        stream,
    input  wire logic                                 next_bit,
    input  wire logic [rbsg_pkg::STEP_W-1:0]          phase_step,
    input  wire logic [rbsg_pkg::ENABLE_W-1:0]        streams_enabled,
    output rbsg_pkg::sine_stage_t                     stage
);

    logic [rbsg_pkg::PHASE_BITS-1:0] phase_reg [rbsg_pkg::STREAM_COUNT];
    logic [rbsg_pkg::STREAM_COUNT-1:0] level_reg;
    rbsg_pkg::sine_stage_t            stage_reg;
    rbsg_pkg::sine_stage_t            stage_next;

    logic [rbsg_pkg::SIDX_W-1:0]      sidx;
    logic                             in_range;
    logic [rbsg_pkg::PHASE_BITS:0]    sum;
    logic                             carry;
    logic [rbsg_pkg::PHASE_BITS-1:0]  phase_next;
    logic                             level_next;
    logic [rbsg_pkg::PHASE_BITS-1:0]  ph;
    logic [rbsg_pkg::TIDX_W-1:0]      tidx;
    logic [rbsg_pkg::QIDX_W-1:0]      rem;
    logic [rbsg_pkg::QIDX_W-1:0]      qidx;
    logic [rbsg_pkg::MAG_W-1:0]       mag;

    // accumulate, encode and look up the sine
    always_comb
    begin
        sidx       = rbsg_pkg::SIDX_W'(stream);
        in_range   = ({1'b0, stream} < (rbsg_pkg::STREAM_W + 1)'(rbsg_pkg::STREAM_COUNT));
        sum        = {1'b0, phase_reg[sidx]}
                   + {1'b0, rbsg_pkg::PHASE_BITS'(phase_step)};
        carry      = sum[rbsg_pkg::PHASE_BITS];
        phase_next = sum[rbsg_pkg::PHASE_BITS-1:0];
        level_next = level_reg[sidx] ^ (carry & next_bit);
        // stream offset of whole quarter turns
        ph         = phase_next + {stream[1:0], {(rbsg_pkg::PHASE_BITS-2){1'b0}}};
        tidx       = ph[rbsg_pkg::PHASE_BITS-1 -: rbsg_pkg::TIDX_W];
        rem        = tidx[rbsg_pkg::QIDX_W-1:0];
        // fold the half turn onto a quarter turn
        if (rem > rbsg_pkg::QIDX_W'(rbsg_pkg::QUARTER))
        begin
            qidx = rbsg_pkg::QIDX_W'(2 * rbsg_pkg::QUARTER) - rem;
        end
        else
        begin
            qidx = rem;
        end
        mag = rbsg_pkg::SINE_TAB[qidx];

        stage_next.mag      = mag;
        stage_next.neg      = (tidx[rbsg_pkg::TIDX_W-1] & (mag != '0)) ^ ~level_next;
        stage_next.taken    = in_range & carry;
        stage_next.in_range = in_range;
        stage_next.audible  = in_range & ({1'b0, stream} < streams_enabled);
    end

    // stream state, updated once per in-range item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rbsg_pkg::STREAM_COUNT; k++)
            begin
                phase_reg[k] <= '0;
            end
            level_reg <= '0;
        end
        else if (load && in_range)
        begin
            phase_reg[sidx] <= phase_next;
            level_reg[sidx] <= level_next;
        end
    end

    // stage payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

/* sv/rbsg_scale.sv */
// gain scaling, saturation, muting and sign stage with the result register
`default_nettype none

module rbsg_scale (
    input  wire logic                                 clk,
    input  wire logic                                 load,
    input  wire rbsg_pkg::sine_stage_t                stage,
    input  wire logic [rbsg_pkg::GAIN_W-1:0]          level_gain,
    output logic [rbsg_pkg::SAMPLE_W-1:0]             sample,
    output logic                                      bit_taken
);

    localparam int PROD_W = rbsg_pkg::MAG_W + rbsg_pkg::GAIN_W;

    logic [PROD_W-1:0]               prod;
    logic [PROD_W:0]                 rounded;
    logic [PROD_W-15:0]              scaled;
    logic [rbsg_pkg::MAG_W-1:0]      mag;
    logic [rbsg_pkg::SAMPLE_W-1:0]   sample_next;
    logic [rbsg_pkg::SAMPLE_W-1:0]   sample_reg;
    logic                            taken_reg;

    // scale, round, clamp, mute and apply the sign
    always_comb
    begin
        prod    = PROD_W'(stage.mag) * PROD_W'(level_gain);
        rounded = {1'b0, prod} + (PROD_W + 1)'(16384);
        scaled  = rounded[PROD_W:15];
        if (scaled > (PROD_W - 14)'(rbsg_pkg::MAG_MAX))
        begin
            mag = rbsg_pkg::MAG_MAX;
        end
        else
        begin
            mag = scaled[rbsg_pkg::MAG_W-1:0];
        end
        if (!stage.audible)
        begin
            mag = '0;
        end
        if (stage.neg)
        begin
            sample_next = rbsg_pkg::SAMPLE_W'(0) - {1'b0, mag};
        end
        else
        begin
            sample_next = {1'b0, mag};
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_next;
            taken_reg  <= stage.taken;
        end
    end

    assign sample    = sample_reg;
    assign bit_taken = taken_reg;

endmodule

`default_nettype wire

/* sv/rds_bpsk_sample_generator_top.sv */
// path from input transfer to result: input, phase/sine and result registers
// throughput: one item per cycle; the three stages stall together only when all hold items
// the per-stream phase is read and written back within the phase stage, so same-stream requests run back to back
// reset: asynchronous active low; phases and encoded levels clear to zero, registers
// return to step 2097152, gain 32768 and one enabled stream; no clearing pass
`default_nettype none

module rds_bpsk_sample_generator_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // slave stream: [2:0] stream, [3] next_bit, [7:4] zero
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [rbsg_pkg::S_TDATA_W-1:0]       s_tdata,
    // master stream: [15:0] sample, [16] bit_taken, [23:17] zero
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [rbsg_pkg::M_TDATA_W-1:0]            m_tdata,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rbsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rbsg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [rbsg_pkg::STEP_W-1:0]   phase_step_reg;
    logic [rbsg_pkg::GAIN_W-1:0]   level_gain_reg;
    logic [rbsg_pkg::ENABLE_W-1:0] streams_enabled_reg;

    logic                          s0_valid_reg;
    logic [rbsg_pkg::STREAM_W-1:0] s0_stream_reg;
    logic                          s0_bit_reg;
    logic                          s1_valid_reg;
    logic                          out_valid_reg;

    logic                          out_free;
    logic                          s1_free;
    logic                          s1_move;
    logic                          s0_move;
    logic                          s0_free;
    logic                          in_xfer;

    rbsg_pkg::sine_stage_t         stage;
    logic [rbsg_pkg::SAMPLE_W-1:0] sample;
    logic                          bit_taken;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg      <= rbsg_pkg::PHASE_STEP_RST;
            level_gain_reg      <= rbsg_pkg::LEVEL_GAIN_RST;
            streams_enabled_reg <= rbsg_pkg::STREAMS_ENABLED_RST;
        end
        else if (cfg_valid)
        begin
            case (rbsg_pkg::cfg_index_t'(cfg_index))
                rbsg_pkg::CFG_PHASE_STEP:
                    phase_step_reg <= cfg_data[rbsg_pkg::STEP_W-1:0];
                rbsg_pkg::CFG_LEVEL_GAIN:
                    level_gain_reg <= cfg_data[rbsg_pkg::GAIN_W-1:0];
                rbsg_pkg::CFG_STREAMS_ENABLED:
                    streams_enabled_reg <= cfg_data[rbsg_pkg::ENABLE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // pipeline flow control
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s0_move  = s0_valid_reg && s1_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign s_tready = s0_free;
    assign in_xfer  = s_tvalid && s_tready;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= s_tvalid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s0_stream_reg <= s_tdata[rbsg_pkg::STREAM_W-1:0];
            s0_bit_reg    <= s_tdata[rbsg_pkg::STREAM_W];
        end
    end

    rbsg_phase u_phase (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (s0_move),
        .stream          (s0_stream_reg),
        .next_bit        (s0_bit_reg),
        .phase_step      (phase_step_reg),
        .streams_enabled (streams_enabled_reg),
        .stage           (stage)
    );

    rbsg_scale u_scale (
        .clk        (clk),
        .load       (s1_move),
        .stage      (stage),
        .level_gain (level_gain_reg),
        .sample     (sample),
        .bit_taken  (bit_taken)
    );

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rbsg_pkg::M_TDATA_W - rbsg_pkg::SAMPLE_W - 1){1'b0}}, bit_taken, sample};

    // an out-of-range request neither takes a bit nor sounds
    a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !stage.in_range) |-> (!stage.taken && !stage.audible))
        else $error("out-of-range stream took a bit or is audible");

    // an item leaving the sine stage shows up as a result next cycle
    a_stage_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> m_tvalid)
        else $error("item lost between sine stage and result register");

    // input stalls only when every stage is occupied and the output is held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s0_valid_reg && s1_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with a free pipeline stage");

endmodule

`default_nettype wire
